FILE: sv/rmat_pkg.sv
// ----------------------------------------------------------------------------
// Rate-monotonic admission test: shared package
// Request codes, verdict codes, fixed widths and the types that pass between
// the command queue, the analysis engine and the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none
package rmat_pkg;

  // Width of the cost and period fields.
  localparam int TW = 16;
  // Width of the utilisation dividend, cost shifted up by 24 bits.
  localparam int DW = TW + 24;

  // Request kinds.
  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_TEST  = 2'd2;

  // Verdicts.
  localparam logic [1:0] V_BOUND = 2'd0;
  localparam logic [1:0] V_RTA   = 2'd1;
  localparam logic [1:0] V_OVER  = 2'd2;
  localparam logic [1:0] V_MISS  = 2'd3;

  // Utilisation limits in Q1.24.
  localparam logic [24:0] Q_ONE   = 25'h1000000;
  localparam logic [24:0] LN2_Q24 = 25'h0B17217;

  // One queued request.
  typedef struct packed {
    logic [1:0]    kind;
    logic [3:0]    slot;
    logic [TW-1:0] cost;
    logic [TW-1:0] period;
  } cmd_t;

  // Divider start request.
  typedef struct packed {
    logic          start;
    logic [DW-1:0] dividend;
    logic [TW-1:0] divisor;
  } div_req_t;

  // Divider status and result.
  typedef struct packed {
    logic          busy;
    logic          done;
    logic [DW-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: sv/rmat_fifo.sv
// ----------------------------------------------------------------------------
// Two-entry queue
// Small register queue used between the front and the engine and in front
// of the result port.
// ----------------------------------------------------------------------------
`default_nettype none
module rmat_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r, wp_nxt;
  logic             rp_r, rp_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rdata   = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and fill count update.
  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

FILE: sv/rmat_div.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned division of a DW-bit dividend by a TW-bit divisor, one quotient
// bit per cycle. The divisor is never zero when a division is started.
// ----------------------------------------------------------------------------
`default_nettype none
module rmat_div
  import rmat_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam int CW = $clog2(DW + 1);

  logic [TW:0]   rem_r, rem_nxt;
  logic [DW-1:0] q_r, q_nxt;
  logic [TW-1:0] dsr_r, dsr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [TW+1:0] shifted;
  logic [TW+1:0] trial;

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = q_r;

  // One restoring step per cycle.
  always_comb begin
    shifted  = {rem_r, q_r[DW-1]};
    trial    = shifted - {2'b00, dsr_r};
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start && !busy_r) begin
      rem_nxt  = '0;
      q_nxt    = req.dividend;
      dsr_nxt  = req.divisor;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[TW+1]) begin
        rem_nxt = trial[TW:0];
        q_nxt   = {q_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[TW:0];
        q_nxt   = {q_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dsr_r <= dsr_nxt;
  end

endmodule
`default_nettype wire

FILE: sv/rmat_engine.sv
// ----------------------------------------------------------------------------
// Admission engine
// Carries out queued requests: keeps the task table, sums utilisation and
// runs exact response-time analysis with the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none
module rmat_engine
  import rmat_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cmd_t     cmd,
  input  wire logic     cmd_empty,
  output logic          cmd_pop,
  input  wire logic     res_full,
  output logic          res_push,
  output logic [1:0]    res_verdict,
  output div_req_t      div_req,
  input  wire div_rsp_t div_rsp
);

  localparam int AW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int IW    = $clog2(MAX_TASKS + 2);
  localparam int SUM_W = DW + 1 + $clog2(MAX_TASKS + 1);
  localparam logic [IW-1:0] CAND = IW'(MAX_TASKS);
  localparam logic [IW-1:0] LAST = IW'(MAX_TASKS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_URD  = 4'd1;
  localparam logic [3:0] S_UWT  = 4'd2;
  localparam logic [3:0] S_UDIV = 4'd3;
  localparam logic [3:0] S_UCHK = 4'd4;
  localparam logic [3:0] S_LDI  = 4'd5;
  localparam logic [3:0] S_WTI  = 4'd6;
  localparam logic [3:0] S_INIT = 4'd7;
  localparam logic [3:0] S_LDJ  = 4'd8;
  localparam logic [3:0] S_WTJ  = 4'd9;
  localparam logic [3:0] S_HP   = 4'd10;
  localparam logic [3:0] S_RDIV = 4'd11;
  localparam logic [3:0] S_MUL  = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  // Task table: cost in the upper half, period in the lower half.
  logic [2*TW-1:0]      mem [MAX_TASKS];
  logic [2*TW-1:0]      rd_data_r;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;

  logic [3:0]           state_r, state_nxt;
  logic [MAX_TASKS-1:0] valid_r, valid_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [IW-1:0]        j_r, j_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [TW-1:0]        cc_r, cc_nxt;
  logic [TW-1:0]        cp_r, cp_nxt;
  logic [TW-1:0]        ci_r, ci_nxt;
  logic [TW-1:0]        pi_r, pi_nxt;
  logic [TW-1:0]        cj_r, cj_nxt;
  logic [TW-1:0]        pj_r, pj_nxt;
  logic [TW-1:0]        rr_r, rr_nxt;
  logic [TW-1:0]        acc_r, acc_nxt;
  logic [2*TW:0]        prod_r, prod_nxt;
  logic [1:0]           verdict_r, verdict_nxt;

  logic                 idx_vld;
  logic                 j_vld;
  logic                 slot_ok;
  logic [TW:0]          ceil_num;
  logic [2*TW+1:0]      acc_sum;
  logic [TW-1:0]        rd_cost;
  logic [TW-1:0]        rd_period;

  assign rd_cost     = rd_data_r[2*TW-1:TW];
  assign rd_period   = rd_data_r[TW-1:0];
  assign idx_vld     = (idx_r < CAND) && valid_r[idx_r[AW-1:0]];
  assign j_vld       = (j_r < CAND) && valid_r[j_r[AW-1:0]];
  assign slot_ok     = (32'(cmd.slot) < MAX_TASKS);
  assign ceil_num    = {1'b0, rr_r} + {1'b0, pj_r} - (TW+1)'(1);
  assign acc_sum     = {{(TW+2){1'b0}}, acc_r} + {1'b0, prod_r};
  assign res_verdict = verdict_r;

  // Sequencer for table updates, utilisation pass and response-time analysis.
  always_comb begin
    state_nxt   = state_r;
    valid_nxt   = valid_r;
    idx_nxt     = idx_r;
    j_nxt       = j_r;
    sum_nxt     = sum_r;
    cc_nxt      = cc_r;
    cp_nxt      = cp_r;
    ci_nxt      = ci_r;
    pi_nxt      = pi_r;
    cj_nxt      = cj_r;
    pj_nxt      = pj_r;
    rr_nxt      = rr_r;
    acc_nxt     = acc_r;
    prod_nxt    = prod_r;
    verdict_nxt = verdict_r;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = idx_r[AW-1:0];
    wr_en       = 1'b0;
    div_req     = '0;
    case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            KIND_SET: begin
              if (slot_ok) begin
                wr_en                     = 1'b1;
                valid_nxt[AW'(cmd.slot)] = 1'b1;
              end
            end
            KIND_CLEAR: begin
              if (slot_ok) begin
                valid_nxt[AW'(cmd.slot)] = 1'b0;
              end
            end
            KIND_TEST: begin
              cc_nxt  = cmd.cost;
              cp_nxt  = cmd.period;
              idx_nxt = '0;
              sum_nxt = '0;
              if (cmd.period == '0) begin
                verdict_nxt = V_OVER;
                state_nxt   = S_DONE;
              end else begin
                state_nxt = S_URD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // Utilisation pass: one term per valid slot, then the candidate.
      S_URD: begin
        if (idx_r == CAND) begin
          div_req.start    = 1'b1;
          div_req.dividend = {cc_r, 24'd0};
          div_req.divisor  = cp_r;
          state_nxt        = S_UDIV;
        end else if (!idx_vld) begin
          idx_nxt = idx_r + IW'(1);
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_UWT;
        end
      end
      S_UWT: begin
        if (rd_period == '0) begin
          verdict_nxt = V_OVER;
          state_nxt   = S_DONE;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {rd_cost, 24'd0};
          div_req.divisor  = rd_period;
          state_nxt        = S_UDIV;
        end
      end
      S_UDIV: begin
        if (div_rsp.done) begin
          sum_nxt = sum_r + SUM_W'(div_rsp.quot);
          if (idx_r == CAND) begin
            state_nxt = S_UCHK;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = S_URD;
          end
        end
      end
      S_UCHK: begin
        idx_nxt = '0;
        if (sum_r > SUM_W'(Q_ONE)) begin
          verdict_nxt = V_OVER;
          state_nxt   = S_DONE;
        end else if (sum_r <= SUM_W'(LN2_Q24)) begin
          verdict_nxt = V_BOUND;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_LDI;
        end
      end
      // Load task i for the analysis.
      S_LDI: begin
        if (idx_r == CAND) begin
          ci_nxt    = cc_r;
          pi_nxt    = cp_r;
          state_nxt = S_INIT;
        end else if (!idx_vld) begin
          idx_nxt = idx_r + IW'(1);
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_WTI;
        end
      end
      S_WTI: begin
        ci_nxt    = rd_cost;
        pi_nxt    = rd_period;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        rr_nxt  = ci_r;
        acc_nxt = ci_r;
        j_nxt   = '0;
        if (ci_r > pi_r) begin
          verdict_nxt = V_MISS;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_LDJ;
        end
      end
      // Walk every other task; those of higher priority add interference.
      S_LDJ: begin
        rd_addr = j_r[AW-1:0];
        if (j_r == LAST) begin
          j_nxt = '0;
          if (acc_r == rr_r) begin
            if (idx_r == CAND) begin
              verdict_nxt = V_RTA;
              state_nxt   = S_DONE;
            end else begin
              idx_nxt   = idx_r + IW'(1);
              state_nxt = S_LDI;
            end
          end else begin
            rr_nxt  = acc_r;
            acc_nxt = ci_r;
          end
        end else if (j_r == idx_r || (j_r != CAND && !j_vld)) begin
          j_nxt = j_r + IW'(1);
        end else if (j_r == CAND) begin
          cj_nxt    = cc_r;
          pj_nxt    = cp_r;
          state_nxt = S_HP;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_WTJ;
        end
      end
      S_WTJ: begin
        cj_nxt    = rd_cost;
        pj_nxt    = rd_period;
        state_nxt = S_HP;
      end
      S_HP: begin
        if (pj_r < pi_r || (pj_r == pi_r && j_r < idx_r)) begin
          div_req.start    = 1'b1;
          div_req.dividend = DW'(ceil_num);
          div_req.divisor  = pj_r;
          state_nxt        = S_RDIV;
        end else begin
          j_nxt     = j_r + IW'(1);
          state_nxt = S_LDJ;
        end
      end
      S_RDIV: begin
        if (div_rsp.done) begin
          prod_nxt  = div_rsp.quot[TW:0] * cj_r;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (acc_sum > {{(TW+2){1'b0}}, pi_r}) begin
          verdict_nxt = V_MISS;
          state_nxt   = S_DONE;
        end else begin
          acc_nxt   = acc_sum[TW-1:0];
          j_nxt     = j_r + IW'(1);
          state_nxt = S_LDJ;
        end
      end
      S_DONE: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    j_r       <= j_nxt;
    sum_r     <= sum_nxt;
    cc_r      <= cc_nxt;
    cp_r      <= cp_nxt;
    ci_r      <= ci_nxt;
    pi_r      <= pi_nxt;
    cj_r      <= cj_nxt;
    pj_r      <= pj_nxt;
    rr_r      <= rr_nxt;
    acc_r     <= acc_nxt;
    prod_r    <= prod_nxt;
    verdict_r <= verdict_nxt;
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(cmd.slot)] <= {cmd.cost, cmd.period};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/rate_monotonic_admission_test.sv
// ----------------------------------------------------------------------------
// Rate-monotonic admission test
// Keeps a table of periodic tasks and answers admission tests by the
// utilisation bound or by exact response-time analysis.
// ----------------------------------------------------------------------------
//   Channel  Ports                                         Handshake
//   input    in_kind, in_slot, in_task_cost, in_task_period in_push / in_full
//   result   out_verdict                                   out_pop / out_empty
//
// A test divides once per valid slot and for the candidate in the utilisation
// pass, on the bit-serial 40-bit divider, and then, if analysed, once per
// interfering task per fixed-point step of every task.
// Reset clears the valid bits and the queues; table entries are undefined
// until written. The front queue keeps taking requests while the engine works.
`default_nettype none
module rate_monotonic_admission_test
  import rmat_pkg::*;
#(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  output logic               in_full,
  input  wire logic [1:0]    in_kind,
  input  wire logic [3:0]    in_slot,
  input  wire logic [TW-1:0] in_task_cost,
  input  wire logic [TW-1:0] in_task_period,
  output logic               out_empty,
  input  wire logic          out_pop,
  output logic [1:0]         out_verdict
);

  localparam int            EFF_BITS = (TIME_BITS < TW) ? TIME_BITS : TW;
  localparam logic [TW-1:0] TMASK    = TW'((33'd1 << EFF_BITS) - 33'd1);

  cmd_t     cmd_in;
  cmd_t     cmd_out;
  logic     cmd_push;
  logic     cmd_full;
  logic     cmd_empty;
  logic     cmd_pop;
  logic     res_full;
  logic     res_push;
  logic [1:0] res_verdict;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Front: mask the fields and drop unused request kinds.
  assign cmd_in.kind   = in_kind;
  assign cmd_in.slot   = in_slot;
  assign cmd_in.cost   = in_task_cost & TMASK;
  assign cmd_in.period = in_task_period & TMASK;
  assign in_full       = cmd_full;
  assign cmd_push      = in_push && (in_kind == KIND_SET || in_kind == KIND_CLEAR ||
                                     in_kind == KIND_TEST);

  rmat_fifo #(.WIDTH($bits(cmd_t))) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  rmat_engine #(.MAX_TASKS(MAX_TASKS)) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd_out),
    .cmd_empty   (cmd_empty),
    .cmd_pop     (cmd_pop),
    .res_full    (res_full),
    .res_push    (res_push),
    .res_verdict (res_verdict),
    .div_req     (div_req),
    .div_rsp     (div_rsp)
  );

  rmat_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rmat_fifo #(.WIDTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_verdict),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_verdict),
    .empty (out_empty)
  );

`ifndef SYNTHESIS
  // The engine never hands a verdict to a full result queue.
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full) else $error("result pushed into full queue");

  // The engine only takes a request that is waiting.
  a_cmd_avail: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty) else $error("request taken from empty queue");

  // A division is never started while one is running.
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy) else $error("divider restarted while busy");
`endif

endmodule
`default_nettype wire
